[rtl/sensor_threshold_alarm_holdoff_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the sensor threshold alarm checker
// Clocked on i_clk, disabled while i_rst_n is low.
// -----------------------------------------------------------------------------
`ifndef SENSOR_THRESHOLD_ALARM_HOLDOFF_MACROS_SVH
`define SENSOR_THRESHOLD_ALARM_HOLDOFF_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define STA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: alarm check failed");

// Consequent checked in the cycle after the antecedent.
`define STA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: alarm check failed");

`endif

[rtl/sta_pkg.sv]
// -----------------------------------------------------------------------------
// sta_pkg
// Shared widths, register indexes, alert kinds and stage types of the
// sensor threshold alarm with per-machine hold-off.
// -----------------------------------------------------------------------------
package sta_pkg;

    localparam int MACH_W            = 4;
    localparam int VAL_W             = 24;
    localparam int TIME_W            = 32;
    localparam int HOLD_W            = 16;
    localparam int KIND_W            = 2;
    localparam int KIND_COUNT        = 4;
    localparam int WIN_COUNT         = 2;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 24;
    localparam int ESC_W             = VAL_W + 4;
    localparam int DEF_MACHINE_COUNT = 16;

    // Alert kinds, also the order in which alerts leave
    localparam logic [KIND_W-1:0] KIND_WEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_YIELD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SPEED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PRESS = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WEAR_WARN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEAR_CRIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YIELD_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF    = 3'd7;

    localparam logic [VAL_W-1:0]  VAL_MAX       = '1;
    localparam logic [VAL_W-1:0]  VAL_ZERO      = '0;
    localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 16'd300;

    typedef struct packed {
        logic [VAL_W-1:0]  wear_warn;
        logic [VAL_W-1:0]  wear_crit;
        logic [VAL_W-1:0]  yield_min;
        logic [VAL_W-1:0]  speed_low;
        logic [VAL_W-1:0]  speed_high;
        logic [VAL_W-1:0]  press_low;
        logic [VAL_W-1:0]  press_high;
        logic [HOLD_W-1:0] holdoff;
    } t_cfg;

    typedef struct packed {
        logic [MACH_W-1:0] machine;
        logic [VAL_W-1:0]  wear;
        logic [VAL_W-1:0]  yld;
        logic [VAL_W-1:0]  speed;
        logic [VAL_W-1:0]  press;
        logic [TIME_W-1:0] time_s;
    } t_sample;

    // Threshold screen result: which kinds fired and against which limit
    typedef struct packed {
        logic [MACH_W-1:0]                   machine;
        logic [TIME_W-1:0]                   time_s;
        logic [KIND_COUNT-1:0]               hit;
        logic                                wear_crit;
        logic [KIND_COUNT-1:0][VAL_W-1:0]    value;
        logic [KIND_COUNT-1:0][VAL_W-1:0]    limit;
        logic [WIN_COUNT-1:0][VAL_W-1:0]     gap;
    } t_screen;

    // Up to four alerts of one sample, one bit of mask per kind
    typedef struct packed {
        logic [MACH_W-1:0]                   machine;
        logic [KIND_COUNT-1:0]               mask;
        logic [KIND_COUNT-1:0]               crit;
        logic [KIND_COUNT-1:0][VAL_W-1:0]    value;
        logic [KIND_COUNT-1:0][VAL_W-1:0]    limit;
    } t_burst;

    // Escalate when gap * 10 > limit * 3, exact, by shifts and adds
    function automatic logic esc_crit(input logic [VAL_W-1:0] gap,
                                      input logic [VAL_W-1:0] limit);
        logic [ESC_W-1:0] d_ext;
        logic [ESC_W-1:0] t_ext;
        logic [ESC_W-1:0] d10;
        logic [ESC_W-1:0] t3;
        d_ext = ESC_W'(gap);
        t_ext = ESC_W'(limit);
        d10   = (d_ext << 3) + (d_ext << 1);
        t3    = (t_ext << 1) + t_ext;
        return d10 > t3;
    endfunction

endpackage

[rtl/sta_screen.sv]
// -----------------------------------------------------------------------------
// sta_screen
// Input register and threshold screen: level compares, window checks and
// distance to the violated limit for speed and pressure.
// -----------------------------------------------------------------------------
module sta_screen #(
    parameter int MACHINE_COUNT = sta_pkg::DEF_MACHINE_COUNT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sta_pkg::t_sample i_sample,
    input  sta_pkg::t_cfg    i_cfg,
    output logic             o_s2_vld,
    output sta_pkg::t_screen o_s2,
    input  logic             i_s2_take
);
    import sta_pkg::*;

    localparam logic ALL_IN_RANGE = (MACHINE_COUNT >= (1 << MACH_W));

    logic    r_s1_vld;
    t_sample r_s1;
    logic    r_s2_vld;
    t_screen r_s2;
    t_screen n_s2;

    logic    s1_adv;
    logic    s2_free;
    logic    in_range;
    logic    wear_crit;
    logic    wear_warn;
    logic [WIN_COUNT-1:0]            lo_x;
    logic [WIN_COUNT-1:0]            hi_x;
    logic [WIN_COUNT-1:0][VAL_W-1:0] win_v;
    logic [WIN_COUNT-1:0][VAL_W-1:0] win_lo;
    logic [WIN_COUNT-1:0][VAL_W-1:0] win_hi;

    assign s2_free    = !r_s2_vld || i_s2_take;
    assign s1_adv     = r_s1_vld && s2_free;
    assign o_in_stall = r_s1_vld && !s2_free;
    assign o_s2_vld   = r_s2_vld;
    assign o_s2       = r_s2;

    always_comb begin
        in_range  = ALL_IN_RANGE || (r_s1.machine < MACH_W'(MACHINE_COUNT));
        wear_crit = r_s1.wear >= i_cfg.wear_crit;
        wear_warn = r_s1.wear >= i_cfg.wear_warn;

        win_v  = {r_s1.press, r_s1.speed};
        win_lo = {i_cfg.press_low, i_cfg.speed_low};
        win_hi = {i_cfg.press_high, i_cfg.speed_high};

        n_s2.machine   = r_s1.machine;
        n_s2.time_s    = r_s1.time_s;
        n_s2.wear_crit = wear_crit;

        n_s2.hit[KIND_WEAR]   = in_range && (wear_crit || wear_warn);
        n_s2.value[KIND_WEAR] = r_s1.wear;
        n_s2.limit[KIND_WEAR] = wear_crit ? i_cfg.wear_crit : i_cfg.wear_warn;

        n_s2.hit[KIND_YIELD]   = in_range && (r_s1.yld < i_cfg.yield_min);
        n_s2.value[KIND_YIELD] = r_s1.yld;
        n_s2.limit[KIND_YIELD] = i_cfg.yield_min;

        // Low bound wins when an inverted window is crossed on both sides
        for (int w = 0; w < WIN_COUNT; w++) begin
            lo_x[w] = win_v[w] < win_lo[w];
            hi_x[w] = win_v[w] > win_hi[w];
            n_s2.hit[int'(KIND_SPEED) + w]   = in_range && (lo_x[w] || hi_x[w]);
            n_s2.value[int'(KIND_SPEED) + w] = win_v[w];
            n_s2.limit[int'(KIND_SPEED) + w] = lo_x[w] ? win_lo[w] : win_hi[w];
            n_s2.gap[w] = lo_x[w] ? (win_lo[w] - win_v[w]) : (win_v[w] - win_hi[w]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (!r_s1_vld || s1_adv) begin
                r_s1_vld <= i_in_valid;
            end
            if (s2_free) begin
                r_s2_vld <= s1_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1 <= i_sample;
        end
        if (s1_adv) begin
            r_s2 <= n_s2;
        end
    end

endmodule

[rtl/sta_holdoff.sv]
// -----------------------------------------------------------------------------
// sta_holdoff
// Escalation and per-machine hold-off. Last alert times sit in one small
// memory per kind; seen bits in flops are cleared by reset.
// -----------------------------------------------------------------------------
module sta_holdoff #(
    parameter int MACHINE_COUNT = sta_pkg::DEF_MACHINE_COUNT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sta_pkg::HOLD_W-1:0]  i_holdoff,
    input  logic                        i_s2_vld,
    input  sta_pkg::t_screen            i_s2,
    output logic                        o_s2_take,
    input  logic                        i_burst_free,
    output logic                        o_burst_load,
    output sta_pkg::t_burst             o_burst
);
    import sta_pkg::*;

    // Machine index is 4 bits wide, so no more slots than it can address
    localparam int MACH_SLOTS = (MACHINE_COUNT < (1 << MACH_W)) ? MACHINE_COUNT
                                                                : (1 << MACH_W);
    localparam int ADDR_W     = (MACH_SLOTS > 1) ? $clog2(MACH_SLOTS) : 1;

    logic                                r_s3_vld;
    t_burst                              r_s3;
    t_burst                              n_s3;
    logic [TIME_W-1:0]                   r_s3_time;
    logic [TIME_W-1:0]                   r_mem [KIND_COUNT][MACH_SLOTS];
    logic [KIND_COUNT-1:0][TIME_W-1:0]   r_rd;
    logic [KIND_COUNT-1:0]               r_fwd_hit;
    logic [TIME_W-1:0]                   r_fwd_time;
    logic [MACH_SLOTS-1:0][KIND_COUNT-1:0] r_seen;

    logic [ADDR_W-1:0]                   rd_addr;
    logic [ADDR_W-1:0]                   wr_addr;
    logic [KIND_COUNT-1:0][TIME_W-1:0]   stored;
    logic [KIND_COUNT-1:0][TIME_W-1:0]   elapsed;
    logic [KIND_COUNT-1:0]               pass;
    logic [KIND_COUNT-1:0]               wr_en;
    logic                                s3_adv;
    logic                                s3_load;

    assign rd_addr = i_s2.machine[ADDR_W-1:0];
    assign wr_addr = r_s3.machine[ADDR_W-1:0];

    always_comb begin
        n_s3.machine            = i_s2.machine;
        n_s3.mask               = i_s2.hit;
        n_s3.value              = i_s2.value;
        n_s3.limit              = i_s2.limit;
        n_s3.crit[KIND_WEAR]    = i_s2.wear_crit;
        n_s3.crit[KIND_YIELD]   = 1'b0;
        n_s3.crit[KIND_SPEED]   = esc_crit(i_s2.gap[0], i_s2.limit[KIND_SPEED]);
        n_s3.crit[KIND_PRESS]   = esc_crit(i_s2.gap[1], i_s2.limit[KIND_PRESS]);
    end

    // Suppress while the wrapped elapsed time is below the hold-off
    always_comb begin
        for (int k = 0; k < KIND_COUNT; k++) begin
            stored[k]  = r_fwd_hit[k] ? r_fwd_time : r_rd[k];
            elapsed[k] = r_s3_time - stored[k];
            pass[k]    = r_s3.mask[k]
                         && !(r_seen[wr_addr][k] && (elapsed[k] < TIME_W'(i_holdoff)));
        end
    end

    assign s3_adv       = r_s3_vld && (!(|pass) || i_burst_free);
    assign wr_en        = pass & {KIND_COUNT{s3_adv}};
    assign o_s2_take    = !r_s3_vld || s3_adv;
    assign s3_load      = i_s2_vld && o_s2_take;
    assign o_burst_load = s3_adv && (|pass);

    always_comb begin
        o_burst      = r_s3;
        o_burst.mask = pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_seen   <= '0;
        end else begin
            if (o_s2_take) begin
                r_s3_vld <= i_s2_vld;
            end
            for (int k = 0; k < KIND_COUNT; k++) begin
                if (wr_en[k]) begin
                    r_seen[wr_addr][k] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < KIND_COUNT; k++) begin
            if (wr_en[k]) begin
                r_mem[k][wr_addr] <= r_s3_time;
            end
        end
    end

    // Read on load; a write at the same edge to the same machine is bypassed
    always_ff @(posedge i_clk) begin
        if (s3_load) begin
            r_s3       <= n_s3;
            r_s3_time  <= i_s2.time_s;
            r_fwd_time <= r_s3_time;
            for (int k = 0; k < KIND_COUNT; k++) begin
                r_rd[k]      <= r_mem[k][rd_addr];
                r_fwd_hit[k] <= wr_en[k] && (r_s3.machine == i_s2.machine);
            end
        end
    end

endmodule

[rtl/sta_serial.sv]
// -----------------------------------------------------------------------------
// sta_serial
// Alert burst register and output register: sends the alerts of one sample
// one per transfer in kind order and flags the final one.
// -----------------------------------------------------------------------------
module sta_serial (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  sta_pkg::t_burst             i_burst,
    output logic                        o_burst_free,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [sta_pkg::MACH_W-1:0]  o_alert_machine,
    output logic [sta_pkg::KIND_W-1:0]  o_alert_kind,
    output logic                        o_alert_critical,
    output logic [sta_pkg::VAL_W-1:0]   o_measured_value,
    output logic [sta_pkg::VAL_W-1:0]   o_violated_limit,
    output logic                        o_last_alert
);
    import sta_pkg::*;

    logic                  r_b_vld;
    t_burst                r_b;
    logic                  r_o_vld;
    logic [MACH_W-1:0]     r_o_machine;
    logic [KIND_W-1:0]     r_o_kind;
    logic                  r_o_crit;
    logic [VAL_W-1:0]      r_o_value;
    logic [VAL_W-1:0]      r_o_limit;
    logic                  r_o_last;

    logic [KIND_W-1:0]     sel;
    logic [KIND_COUNT-1:0] rem;
    logic                  out_free;
    logic                  pop;

    // Lowest pending kind goes first
    always_comb begin
        sel = KIND_WEAR;
        for (int k = KIND_COUNT - 1; k >= 0; k--) begin
            if (r_b.mask[k]) begin
                sel = KIND_W'(k);
            end
        end
        rem = r_b.mask & ~(KIND_COUNT'(1) << sel);
    end

    assign out_free     = !r_o_vld || !i_out_stall;
    assign pop          = r_b_vld && out_free;
    assign o_burst_free = !r_b_vld || (pop && (rem == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (i_load) begin
                r_b_vld <= 1'b1;
            end else if (pop && (rem == '0)) begin
                r_b_vld <= 1'b0;
            end
            if (out_free) begin
                r_o_vld <= pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b <= i_burst;
        end else if (pop) begin
            r_b.mask <= rem;
        end
        if (pop) begin
            r_o_machine <= r_b.machine;
            r_o_kind    <= sel;
            r_o_crit    <= r_b.crit[sel];
            r_o_value   <= r_b.value[sel];
            r_o_limit   <= r_b.limit[sel];
            r_o_last    <= (rem == '0);
        end
    end

    assign o_out_valid      = r_o_vld;
    assign o_alert_machine  = r_o_machine;
    assign o_alert_kind     = r_o_kind;
    assign o_alert_critical = r_o_crit;
    assign o_measured_value = r_o_value;
    assign o_violated_limit = r_o_limit;
    assign o_last_alert     = r_o_last;

endmodule

[rtl/sensor_threshold_alarm_holdoff.sv]
// -----------------------------------------------------------------------------
// sensor_threshold_alarm_holdoff
// Checks wear, yield, speed and pressure of each machine sample against
// configured limits and emits alerts, each kind held off per machine.
// -----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+--------------------------------------
//  sample   | in  | i_in_valid / o_in_stall | machine, wear, yield, speed, pressure,
//           |     |                        | time in seconds
//  alert    | out | o_out_valid/i_out_stall| machine, kind, critical, value, limit,
//           |     |                        | last flag
//  config   | in  | i_cfg_we               | i_cfg_index, i_cfg_data
//
// A sample is taken every cycle as long as it raises at most one alert and the
// alert port is not stalled; a sample with more alerts holds up the samples behind
// it while the one-alert-per-transfer output register sends them. The first alert
// passes the input, screen, hold-off, burst and output registers after the sample
// transfer. Reset restores the register defaults and clears the hold-off seen bits.
// An output stall backs up through the stages and reaches o_in_stall in the same cycle.
// -----------------------------------------------------------------------------
module sensor_threshold_alarm_holdoff #(
    parameter int MACHINE_COUNT = sta_pkg::DEF_MACHINE_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sta_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sta_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sta_pkg::MACH_W-1:0]    i_machine_index,
    input  logic [sta_pkg::VAL_W-1:0]     i_wear_value,
    input  logic [sta_pkg::VAL_W-1:0]     i_yield_value,
    input  logic [sta_pkg::VAL_W-1:0]     i_speed_value,
    input  logic [sta_pkg::VAL_W-1:0]     i_pressure_value,
    input  logic [sta_pkg::TIME_W-1:0]    i_time_seconds,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sta_pkg::MACH_W-1:0]    o_alert_machine,
    output logic [sta_pkg::KIND_W-1:0]    o_alert_kind,
    output logic                          o_alert_critical,
    output logic [sta_pkg::VAL_W-1:0]     o_measured_value,
    output logic [sta_pkg::VAL_W-1:0]     o_violated_limit,
    output logic                          o_last_alert
);
    import sta_pkg::*;

    t_cfg    r_cfg;
    t_sample sample;
    logic    s2_vld;
    t_screen s2;
    logic    s2_take;
    logic    burst_free;
    logic    burst_load;
    t_burst  burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wear_warn  <= VAL_MAX;
            r_cfg.wear_crit  <= VAL_MAX;
            r_cfg.yield_min  <= VAL_ZERO;
            r_cfg.speed_low  <= VAL_ZERO;
            r_cfg.speed_high <= VAL_MAX;
            r_cfg.press_low  <= VAL_ZERO;
            r_cfg.press_high <= VAL_MAX;
            r_cfg.holdoff    <= HOLDOFF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WEAR_WARN:  r_cfg.wear_warn  <= i_cfg_data;
                REG_WEAR_CRIT:  r_cfg.wear_crit  <= i_cfg_data;
                REG_YIELD_MIN:  r_cfg.yield_min  <= i_cfg_data;
                REG_SPEED_LOW:  r_cfg.speed_low  <= i_cfg_data;
                REG_SPEED_HIGH: r_cfg.speed_high <= i_cfg_data;
                REG_PRESS_LOW:  r_cfg.press_low  <= i_cfg_data;
                REG_PRESS_HIGH: r_cfg.press_high <= i_cfg_data;
                REG_HOLDOFF:    r_cfg.holdoff    <= i_cfg_data[HOLD_W-1:0];
            endcase
        end
    end

    always_comb begin
        sample.machine = i_machine_index;
        sample.wear    = i_wear_value;
        sample.yld     = i_yield_value;
        sample.speed   = i_speed_value;
        sample.press   = i_pressure_value;
        sample.time_s  = i_time_seconds;
    end

    sta_screen #(
        .MACHINE_COUNT (MACHINE_COUNT)
    ) u_screen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (sample),
        .i_cfg      (r_cfg),
        .o_s2_vld   (s2_vld),
        .o_s2       (s2),
        .i_s2_take  (s2_take)
    );

    sta_holdoff #(
        .MACHINE_COUNT (MACHINE_COUNT)
    ) u_holdoff (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_holdoff    (r_cfg.holdoff),
        .i_s2_vld     (s2_vld),
        .i_s2         (s2),
        .o_s2_take    (s2_take),
        .i_burst_free (burst_free),
        .o_burst_load (burst_load),
        .o_burst      (burst)
    );

    sta_serial u_serial (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (burst_load),
        .i_burst          (burst),
        .o_burst_free     (burst_free),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_alert_machine  (o_alert_machine),
        .o_alert_kind     (o_alert_kind),
        .o_alert_critical (o_alert_critical),
        .o_measured_value (o_measured_value),
        .o_violated_limit (o_violated_limit),
        .o_last_alert     (o_last_alert)
    );

endmodule

[rtl/sta_checker.sv]
// -----------------------------------------------------------------------------
// sta_checker
// Port-level checks of the alert stream, bound to the top level.
// -----------------------------------------------------------------------------
`include "sensor_threshold_alarm_holdoff_macros.svh"

module sta_checker #(
    parameter int MACHINE_COUNT = sta_pkg::DEF_MACHINE_COUNT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_out_stall,
    input  logic                       o_out_valid,
    input  logic [sta_pkg::MACH_W-1:0] o_alert_machine,
    input  logic [sta_pkg::KIND_W-1:0] o_alert_kind,
    input  logic                       o_alert_critical,
    input  logic [sta_pkg::VAL_W-1:0]  o_measured_value,
    input  logic [sta_pkg::VAL_W-1:0]  o_violated_limit,
    input  logic                       o_last_alert
);
    import sta_pkg::*;

    // Hold a stalled alert as it is
    `STA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_alert_machine) && $stable(o_alert_kind) && $stable(o_alert_critical) && $stable(o_measured_value) && $stable(o_violated_limit) && $stable(o_last_alert))

    // An alert that is not the last of its sample is followed at once by
    // a higher kind of the same machine
    `STA_ASSERT_NEXT(a_burst_cont, o_out_valid && !i_out_stall && !o_last_alert, o_out_valid && (o_alert_machine == $past(o_alert_machine)) && (o_alert_kind > $past(o_alert_kind)))

    `STA_ASSERT_SAME(a_yield_warn, o_out_valid && (o_alert_kind == KIND_YIELD), !o_alert_critical)

    `STA_ASSERT_SAME(a_machine_rng, o_out_valid, o_alert_machine < MACHINE_COUNT)

endmodule

bind sensor_threshold_alarm_holdoff sta_checker #(
    .MACHINE_COUNT (MACHINE_COUNT)
) u_sta_checker (.*);

[dv/sensor_threshold_alarm_holdoff_tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sensor_threshold_alarm_holdoff_tb
// Self-checking bench for the sensor alarm block. A queue of machine samples
// feeds a valid/stall driver. Each accepted sample runs through an in-bench
// alarm predictor with its own hold-off table. A monitor compares every alert
// transfer against the oldest predicted alert, field by field. Directed corner
// samples come first, then random phases under several limit settings and
// idle patterns.
// -----------------------------------------------------------------------------
module sensor_threshold_alarm_holdoff_tb;

    import sta_pkg::*;

    localparam int MACHINE_COUNT    = DEF_MACHINE_COUNT;
    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_SAMPLES    = 66;
    localparam int TIMEOUT_CYCLES   = 200_000;

    typedef struct packed {
        logic [MACH_W-1:0] machine;
        logic [KIND_W-1:0] kind;
        logic              critical;
        logic [VAL_W-1:0]  value;
        logic [VAL_W-1:0]  limit;
        logic              last;
    } t_alert;

    typedef struct packed {
        t_sample sample;
        logic    after_drain;
    } t_queued_sample;

    logic                  i_clk;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_stall;
    logic [MACH_W-1:0]     i_machine_index  = '0;
    logic [VAL_W-1:0]      i_wear_value     = '0;
    logic [VAL_W-1:0]      i_yield_value    = '0;
    logic [VAL_W-1:0]      i_speed_value    = '0;
    logic [VAL_W-1:0]      i_pressure_value = '0;
    logic [TIME_W-1:0]     i_time_seconds   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall      = 1'b0;
    logic [MACH_W-1:0]     o_alert_machine;
    logic [KIND_W-1:0]     o_alert_kind;
    logic                  o_alert_critical;
    logic [VAL_W-1:0]      o_measured_value;
    logic [VAL_W-1:0]      o_violated_limit;
    logic                  o_last_alert;

    // Predictor state
    t_cfg              limits_now;
    logic [TIME_W-1:0] stamp_table [MACHINE_COUNT*KIND_COUNT];
    bit                stamp_seen  [MACHINE_COUNT*KIND_COUNT];

    t_queued_sample    samples_pending [$];
    t_alert            alerts_due      [$];

    t_queued_sample    offer_item;
    bit                offer_busy     = 1'b0;
    int unsigned       n_offered      = 0;
    int unsigned       n_taken        = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                long_hold_req  = 0;
    int                long_hold_done = 0;
    int                hold_left      = 0;
    int                fail_count     = 0;
    logic [TIME_W-1:0] sample_clock   = '0;
    t_sample           taken_sample;
    t_alert            due_alert;

    sensor_threshold_alarm_holdoff #(
        .MACHINE_COUNT(MACHINE_COUNT)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_machine_index (i_machine_index),
        .i_wear_value    (i_wear_value),
        .i_yield_value   (i_yield_value),
        .i_speed_value   (i_speed_value),
        .i_pressure_value(i_pressure_value),
        .i_time_seconds  (i_time_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_alert_machine (o_alert_machine),
        .o_alert_kind    (o_alert_kind),
        .o_alert_critical(o_alert_critical),
        .o_measured_value(o_measured_value),
        .o_violated_limit(o_violated_limit),
        .o_last_alert    (o_last_alert)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

    // Pass when the pair is not held off; record the emit time if so
    function automatic bit holdoff_clear(input logic [MACH_W-1:0] machine,
                                         input logic [KIND_W-1:0] kind,
                                         input logic [TIME_W-1:0] now);
        int                slot;
        logic [TIME_W-1:0] elapsed;
        slot = int'(machine) * KIND_COUNT + int'(kind);
        if (stamp_seen[slot]) begin
            elapsed = now - stamp_table[slot];
            if (elapsed < TIME_W'(limits_now.holdoff))
                return 1'b0;
        end
        stamp_table[slot] = now;
        stamp_seen[slot]  = 1'b1;
        return 1'b1;
    endfunction

    function automatic void predict_alerts(input t_sample s);
        t_alert           found [$];
        t_alert           a;
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        logic [VAL_W-1:0] lim;
        logic [VAL_W-1:0] gap;
        logic [ESC_W-1:0] d10;
        logic [ESC_W-1:0] t3;
        if (s.machine >= MACHINE_COUNT)
            return;
        if (s.wear >= limits_now.wear_crit) begin
            if (holdoff_clear(s.machine, KIND_WEAR, s.time_s)) begin
                a = '{s.machine, KIND_WEAR, 1'b1, s.wear, limits_now.wear_crit, 1'b0};
                found.insert(found.size(), a);
            end
        end else if (s.wear >= limits_now.wear_warn) begin
            if (holdoff_clear(s.machine, KIND_WEAR, s.time_s)) begin
                a = '{s.machine, KIND_WEAR, 1'b0, s.wear, limits_now.wear_warn, 1'b0};
                found.insert(found.size(), a);
            end
        end
        if (s.yld < limits_now.yield_min) begin
            if (holdoff_clear(s.machine, KIND_YIELD, s.time_s)) begin
                a = '{s.machine, KIND_YIELD, 1'b0, s.yld, limits_now.yield_min, 1'b0};
                found.insert(found.size(), a);
            end
        end
        for (int k = KIND_SPEED; k <= KIND_PRESS; k++) begin
            v  = (k == KIND_SPEED) ? s.speed : s.press;
            lo = (k == KIND_SPEED) ? limits_now.speed_low : limits_now.press_low;
            hi = (k == KIND_SPEED) ? limits_now.speed_high : limits_now.press_high;
            if (v < lo || v > hi) begin
                if (holdoff_clear(s.machine, KIND_W'(k), s.time_s)) begin
                    // low bound wins when an inverted window is crossed on both sides
                    lim  = (v < lo) ? lo : hi;
                    gap  = (v > lim) ? v - lim : lim - v;
                    d10  = ESC_W'(ESC_W'(gap) * 10);
                    t3   = ESC_W'(ESC_W'(lim) * 3);
                    a = '{s.machine, KIND_W'(k), d10 > t3, v, lim, 1'b0};
                    found.insert(found.size(), a);
                end
            end
        end
        if (found.size() != 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            alerts_due.insert(alerts_due.size(), found[i]);
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endfunction

    // Sample driver: hold payload while stalled, roll idle gaps between transfers
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (offer_busy && n_taken == n_offered)
                offer_busy = 1'b0;
            if (!offer_busy && samples_pending.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                if (!samples_pending[0].after_drain ||
                    (alerts_due.size() == 0 && n_taken == n_offered)) begin
                    offer_item = samples_pending.pop_front();
                    i_machine_index  <= offer_item.sample.machine;
                    i_wear_value     <= offer_item.sample.wear;
                    i_yield_value    <= offer_item.sample.yld;
                    i_speed_value    <= offer_item.sample.speed;
                    i_pressure_value <= offer_item.sample.press;
                    i_time_seconds   <= offer_item.sample.time_s;
                    offer_busy = 1'b1;
                    n_offered++;
                end
            end
            i_in_valid <= offer_busy;
        end
    end

    // Alert receiver: random stall, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left == 0 && long_hold_req != long_hold_done)
                hold_left = LONG_HOLD_CYCLES;
            if (hold_left != 0) begin
                hold_left--;
                if (hold_left == 0)
                    long_hold_done++;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            taken_sample.machine = i_machine_index;
            taken_sample.wear    = i_wear_value;
            taken_sample.yld     = i_yield_value;
            taken_sample.speed   = i_speed_value;
            taken_sample.press   = i_pressure_value;
            taken_sample.time_s  = i_time_seconds;
            predict_alerts(taken_sample);
            n_taken++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (alerts_due.size() == 0) begin
                $error("unexpected alert: machine %0d kind %0d value 0x%0h",
                       o_alert_machine, o_alert_kind, o_measured_value);
                fail_count++;
            end else begin
                due_alert = alerts_due.pop_front();
                check_field("alert_machine", 32'(due_alert.machine), 32'(o_alert_machine));
                check_field("alert_kind", 32'(due_alert.kind), 32'(o_alert_kind));
                check_field("alert_critical", 32'(due_alert.critical),
                            32'(o_alert_critical));
                check_field("measured_value", 32'(due_alert.value), 32'(o_measured_value));
                check_field("violated_limit", 32'(due_alert.limit), 32'(o_violated_limit));
                check_field("last_alert", 32'(due_alert.last), 32'(o_last_alert));
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic apply_limits(input t_cfg c);
        write_reg(REG_WEAR_WARN, c.wear_warn);
        write_reg(REG_WEAR_CRIT, c.wear_crit);
        write_reg(REG_YIELD_MIN, c.yield_min);
        write_reg(REG_SPEED_LOW, c.speed_low);
        write_reg(REG_SPEED_HIGH, c.speed_high);
        write_reg(REG_PRESS_LOW, c.press_low);
        write_reg(REG_PRESS_HIGH, c.press_high);
        // upper data bits are not part of the hold-off register
        write_reg(REG_HOLDOFF, {8'($urandom), c.holdoff});
        limits_now = c;
    endtask

    // Wait for every sample to go in and every alert to come out, then settle
    task automatic wait_quiet();
        while (samples_pending.size() != 0 || offer_busy || alerts_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_sample(input logic [MACH_W-1:0] m, input logic [VAL_W-1:0] w,
                              input logic [VAL_W-1:0] y, input logic [VAL_W-1:0] sp,
                              input logic [VAL_W-1:0] pr, input logic [TIME_W-1:0] t,
                              input bit after_drain);
        t_queued_sample q;
        q.sample      = '{m, w, y, sp, pr, t};
        q.after_drain = after_drain;
        samples_pending.insert(samples_pending.size(), q);
    endtask

    // Value near a bound, near the escalation point, inside the window or anywhere
    function automatic logic [VAL_W-1:0] probe_value(input logic [VAL_W-1:0] lo,
                                                     input logic [VAL_W-1:0] hi);
        longint v;
        longint l;
        longint h;
        l = longint'(lo);
        h = longint'(hi);
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = longint'(VAL_MAX);
            2, 3:    v = longint'($urandom) & longint'(VAL_MAX);
            4:       v = l + longint'($urandom_range(0, 4)) - 2;
            5:       v = h + longint'($urandom_range(0, 4)) - 2;
            6:       v = l - (l * 3) / 10 + longint'($urandom_range(0, 2)) - 1;
            7:       v = h + (h * 3) / 10 + longint'($urandom_range(0, 2)) - 1;
            default: v = (h >= l) ? l + longint'($urandom) % (h - l + 1) : l;
        endcase
        if (v < 0)
            v = 0;
        if (v > longint'(VAL_MAX))
            v = longint'(VAL_MAX);
        return v[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return VAL_ZERO;
            1:       return VAL_MAX;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic t_cfg random_limits(input bit wild);
        t_cfg c;
        if (wild) begin
            c.wear_warn  = pick_level();
            c.wear_crit  = pick_level();
            c.yield_min  = pick_level();
            c.speed_low  = pick_level();
            c.speed_high = pick_level();
            c.press_low  = pick_level();
            c.press_high = pick_level();
        end else begin
            c.wear_warn  = VAL_W'($urandom_range(100, 4000));
            c.wear_crit  = VAL_W'(c.wear_warn + $urandom_range(0, 4000));
            c.yield_min  = VAL_W'($urandom_range(100, 4000));
            c.speed_low  = VAL_W'($urandom_range(100, 4000));
            c.speed_high = VAL_W'(c.speed_low + $urandom_range(0, 4000));
            c.press_low  = VAL_W'($urandom_range(100, 4000));
            c.press_high = VAL_W'(c.press_low + $urandom_range(0, 4000));
        end
        case ($urandom_range(0, 3))
            0:       c.holdoff = '0;
            1:       c.holdoff = '1;
            2:       c.holdoff = HOLD_W'($urandom_range(1, 40));
            default: c.holdoff = HOLD_W'($urandom);
        endcase
        return c;
    endfunction

    task automatic add_random_sample(input bit after_drain);
        logic [MACH_W-1:0] m;
        m = ($urandom_range(0, 9) < 7) ? MACH_W'($urandom_range(0, 3))
                                       : MACH_W'($urandom_range(0, 15));
        // advance mostly around the hold-off period; jump, wrap or go back now and then
        case ($urandom_range(0, 19))
            0:       sample_clock = $urandom;
            1:       sample_clock = sample_clock - $urandom_range(1, 50);
            2:       sample_clock = 32'hFFFF_FFFF - $urandom_range(0, 20);
            default: sample_clock = sample_clock +
                         $urandom_range(0, 2 * int'(limits_now.holdoff) + 2);
        endcase
        add_sample(m,
                   probe_value(limits_now.wear_warn, limits_now.wear_crit),
                   probe_value(limits_now.yield_min, limits_now.yield_min),
                   probe_value(limits_now.speed_low, limits_now.speed_high),
                   probe_value(limits_now.press_low, limits_now.press_high),
                   sample_clock, after_drain);
    endtask

    initial begin
        t_cfg c;
        int   guard;
        limits_now = '{VAL_MAX, VAL_MAX, VAL_ZERO, VAL_ZERO, VAL_MAX,
                       VAL_ZERO, VAL_MAX, HOLDOFF_RESET};
        foreach (stamp_seen[i])
            stamp_seen[i] = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: bounds, escalation edges, all four alerts, zero hold-off
        apply_limits('{24'd1000, 24'd2000, 24'd500, 24'd1000, 24'd2000,
                       24'd1000, 24'd2000, 16'd0});
        add_sample(4'd0, 24'd0, 24'd1000, 24'd1500, 24'd1500, 32'd0, 1'b0);
        add_sample(4'd1, 24'd1000, 24'd1000, 24'd1500, 24'd1500, 32'd1, 1'b0);
        add_sample(4'd1, 24'd1999, 24'd1000, 24'd1500, 24'd1500, 32'd1, 1'b0);
        add_sample(4'd1, 24'd2000, 24'd1000, 24'd1500, 24'd1500, 32'd1, 1'b0);
        add_sample(4'd15, VAL_MAX, 24'd1000, 24'd1500, 24'd1500, '1, 1'b0);
        add_sample(4'd2, 24'd0, 24'd499, 24'd1500, 24'd1500, 32'd2, 1'b0);
        add_sample(4'd2, 24'd0, 24'd0, 24'd1500, 24'd1500, 32'd2, 1'b0);
        add_sample(4'd3, 24'd0, 24'd1000, 24'd999, 24'd1500, 32'd3, 1'b0);
        add_sample(4'd3, 24'd0, 24'd1000, 24'd700, 24'd1500, 32'd3, 1'b0);
        add_sample(4'd3, 24'd0, 24'd1000, 24'd699, 24'd1500, 32'd3, 1'b0);
        add_sample(4'd3, 24'd0, 24'd1000, 24'd2600, 24'd1500, 32'd3, 1'b0);
        add_sample(4'd3, 24'd0, 24'd1000, 24'd2601, 24'd1500, 32'd3, 1'b0);
        add_sample(4'd3, 24'd0, 24'd1000, VAL_MAX, 24'd1500, 32'd3, 1'b0);
        add_sample(4'd4, 24'd0, 24'd1000, 24'd1500, 24'd700, 32'd4, 1'b0);
        add_sample(4'd4, 24'd0, 24'd1000, 24'd1500, 24'd699, 32'd4, 1'b0);
        add_sample(4'd4, 24'd0, 24'd1000, 24'd1500, 24'd2601, 32'd4, 1'b0);
        add_sample(4'd4, 24'd0, 24'd1000, 24'd1500, 24'd0, 32'd4, 1'b0);
        add_sample(4'd15, VAL_MAX, 24'd0, 24'd0, VAL_MAX, 32'd5, 1'b0);
        wait_quiet();

        // Directed: inverted speed window, hold-off expiry, wrap and backward time
        apply_limits('{24'd1000, 24'd2000, 24'd500, 24'd3000, 24'd1000,
                       24'd1000, 24'd2000, 16'd10});
        add_sample(4'd5, 24'd1500, 24'd1000, 24'd2000, 24'd1500, 32'd100, 1'b0);
        add_sample(4'd5, 24'd1500, 24'd1000, 24'd2000, 24'd1500, 32'd105, 1'b0);
        add_sample(4'd5, 24'd1500, 24'd1000, 24'd2000, 24'd1500, 32'd110, 1'b0);
        add_sample(4'd6, 24'd1500, 24'd1000, 24'd3000, 24'd1500, 32'hFFFF_FFF8, 1'b0);
        add_sample(4'd6, 24'd1500, 24'd1000, 24'd3000, 24'd1500, 32'd2, 1'b0);
        add_sample(4'd6, 24'd1500, 24'd1000, 24'd3000, 24'd1500, 32'd1, 1'b0);

        for (int ph = 0; ph < 6; ph++) begin
            wait_quiet();
            case (ph)
                0: begin
                    c = random_limits(1'b0);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    c = random_limits(1'b1);
                    send_idle_pct = 68; recv_stall_pct = 0;
                end
                2: begin
                    c = '{VAL_ZERO, VAL_ZERO, VAL_ZERO, VAL_ZERO, VAL_ZERO,
                          VAL_ZERO, VAL_ZERO, 16'd0};
                    send_idle_pct = 0;  recv_stall_pct = 68;
                end
                3: begin
                    c = '{VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
                          VAL_MAX, VAL_MAX, 16'hFFFF};
                    send_idle_pct = 26; recv_stall_pct = 26;
                end
                4: begin
                    c = random_limits(1'b0);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                default: begin
                    c = random_limits(1'b1);
                    send_idle_pct = 0;  recv_stall_pct = 68;
                end
            endcase
            apply_limits(c);
            sample_clock = $urandom;
            // back the block up against a held receiver while samples keep coming
            if (ph == 4)
                long_hold_req++;
            for (int i = 0; i < PHASE_SAMPLES; i++)
                add_random_sample(ph == 5 && i == PHASE_SAMPLES / 2);
        end

        guard = 0;
        while ((samples_pending.size() != 0 || offer_busy || alerts_due.size() != 0) &&
               guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (samples_pending.size() != 0 || offer_busy) begin
            $error("%0d samples never accepted", samples_pending.size() + int'(offer_busy));
            fail_count++;
        end
        if (alerts_due.size() != 0) begin
            $error("%0d predicted alerts never arrived", alerts_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
